// ----- rtl/pst_pkg.sv -----
`timescale 1ns / 1ps
package pst_pkg;

   localparam logic [23:0] LN2_Q24 = 24'd11629080;

   localparam logic [1:0] FUNC_EVENT    = 2'd0;
   localparam logic [1:0] FUNC_PARTICLE = 2'd1;
   localparam logic [1:0] FUNC_READ     = 2'd2;

   localparam logic [1:0] OBS_PT       = 2'd0;
   localparam logic [1:0] OBS_RAPIDITY = 2'd1;

   localparam logic [2:0] REG_CONTROL    = 3'd0;
   localparam logic [2:0] REG_VALUE_WIN  = 3'd1;
   localparam logic [2:0] REG_RAP_WIN    = 3'd2;
   localparam logic [2:0] REG_CENT_WIN   = 3'd3;
   localparam logic [2:0] REG_STATUS_WIN = 3'd4;
   localparam logic [2:0] REG_ID_LIST    = 3'd5;
   localparam logic [2:0] REG_BIN_SCALE  = 3'd6;
   localparam logic [2:0] REG_CENT_EN    = 3'd7;

   typedef struct packed {
      logic [5:0]  control;
      logic [63:0] value_window;
      logic [63:0] rapidity_window;
      logic [31:0] centrality_window;
      logic [31:0] status_window;
      logic [63:0] id_list;
      logic [31:0] bin_scale;
      logic        centrality_enable;
   } cfg_type;

   // classified request as it travels through the queue
   typedef struct packed {
      logic [1:0]         func;
      logic               ev_pass;
      logic               part_ok;
      logic signed [31:0] mom_x;
      logic signed [31:0] mom_y;
      logic signed [31:0] mom_z;
      logic [30:0]        energy;
      logic [30:0]        mass;
      logic [5:0]         read_index;
   } cmd_type;

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] r;
   } sqrt_type;

   // one digit of the bitwise integer square root
   function automatic sqrt_type sqrt_step(sqrt_type s, logic [63:0] b);
      sqrt_type    o;
      logic [63:0] t;
      t = s.r + b;
      if (s.v >= t) begin
         o.v = s.v - t;
         o.r = (s.r >> 1) + b;
      end else begin
         o.v = s.v;
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   function automatic logic [31:0] abs32(logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

endpackage

// ----- rtl/pst_ram.sv -----
`timescale 1ns / 1ps
module pst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/pst_queue.sv -----
`timescale 1ns / 1ps
module pst_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pst_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             q_valid,
   input  logic             pop,
   output pst_pkg::cmd_type q_cmd
);
   import pst_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   assign full    = cnt_ff[1];
   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd   = slot_ff[rd_ff];
endmodule

// ----- rtl/pst_front.sv -----
`timescale 1ns / 1ps
module pst_front #(
   parameter int MAX_IDS = 4
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_impact_param,
   input  logic [15:0]        req_particle_status,
   input  logic signed [15:0] req_particle_id,
   input  logic signed [31:0] req_mom_x,
   input  logic signed [31:0] req_mom_y,
   input  logic signed [31:0] req_mom_z,
   input  logic [30:0]        req_energy_in,
   input  logic [30:0]        req_mass_in,
   input  logic [5:0]         req_read_index,
   input  pst_pkg::cfg_type   cfg,
   input  logic               clearing,
   input  logic               q_full,
   output logic               push,
   output pst_pkg::cmd_type   push_cmd
);
   import pst_pkg::*;

   logic        cent_ok, stat_ok, id_ok, anti;
   logic [2:0]  nids;
   logic [15:0] slot;
   logic [16:0] id17, negslot;

   always_comb begin
      anti    = cfg.control[2];
      nids    = (cfg.control[5:3] > 3'(MAX_IDS)) ? 3'(MAX_IDS) : cfg.control[5:3];
      id17    = {req_particle_id[15], req_particle_id};
      id_ok   = 1'b0;
      slot    = '0;
      negslot = '0;
      for (int k = 0; k < MAX_IDS; k++) begin
         slot    = cfg.id_list[16*k +: 16];
         negslot = 17'(-{slot[15], slot});
         if (3'(k) < nids && (req_particle_id == slot || (anti && id17 == negslot))) begin
            id_ok = 1'b1;
         end
      end
      stat_ok = req_particle_status >= cfg.status_window[15:0]
                && req_particle_status <= cfg.status_window[31:16];
      cent_ok = !cfg.centrality_enable
                || (req_impact_param >= cfg.centrality_window[15:0]
                    && req_impact_param <= cfg.centrality_window[31:16]);

      push_cmd.func       = req_func;
      push_cmd.ev_pass    = cent_ok;
      push_cmd.part_ok    = stat_ok && id_ok;
      push_cmd.mom_x      = req_mom_x;
      push_cmd.mom_y      = req_mom_y;
      push_cmd.mom_z      = req_mom_z;
      push_cmd.energy     = req_energy_in;
      push_cmd.mass       = req_mass_in;
      push_cmd.read_index = req_read_index;
   end

   assign req_ready = !q_full && !clearing;
   assign push      = req_valid && req_ready;
endmodule

// ----- rtl/pst_back.sv -----
`timescale 1ns / 1ps
module pst_back #(
   parameter int NUM_BINS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  pst_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  pst_pkg::cmd_type q_cmd,
   output logic             pop,
   output logic             clearing,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_accepted,
   output logic [5:0]       rsp_bin_index,
   output logic [31:0]      rsp_bin_count,
   output logic [31:0]      rsp_event_count
);
   import pst_pkg::*;

   localparam int AW = $clog2(NUM_BINS);

   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_SQ    = 12'b000000000100,
      S_SQRT  = 12'b000000001000,
      S_NORM  = 12'b000000010000,
      S_LOG   = 12'b000000100000,
      S_LN    = 12'b000001000000,
      S_CHK   = 12'b000010000000,
      S_BIN   = 12'b000100000000,
      S_UPD   = 12'b001000000000,
      S_RD    = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;
   cmd_type     cmd_ff, cmd_in;
   logic        pass_ff, pass_in;
   logic [31:0] events_ff, events_in;

   logic [63:0] sqp_ff, sqp_in;
   sqrt_type    s1_ff, s1_in, s2_ff, s2_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] na_ff, na_in, nb_ff, nb_in;
   logic [4:0]  sa_ff, sa_in, sb_ff, sb_in;
   logic [30:0] mant_ff, mant_in;
   logic [29:0] frac_ff, frac_in;
   logic        ph_ff, ph_in;
   logic [34:0] la_ff, la_in, d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [59:0] ln_ff, ln_in;
   logic signed [31:0] y_ff, y_in;
   logic [31:0] diff_ff, diff_in;
   logic [AW-1:0] bin_ff, bin_in;

   logic        res_acc_ff, res_acc_in;
   logic [5:0]  res_bin_ff, res_bin_in;
   logic [31:0] res_cnt_ff, res_cnt_in;

   logic        rv_ff, rv_in, racc_ff;
   logic [5:0]  rbin_ff;
   logic [31:0] rcnt_ff, revt_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [31:0] sqv;
   logic [63:0] sbit;
   logic [4:0]  shk;
   logic [34:0] lbv;
   logic [59:0] lnsum;
   logic [21:0] mag;
   logic signed [32:0] val, vmin, vmax, rmin, rmax, y33, dv;
   logic [31:0] idx, oldc, addv;
   logic        ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0] ram_wdata, ram_rdata;
   logic        out_free;

   pst_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            if (cnt_ff == 5'd0) begin
               mul_a = abs32(cmd_ff.mom_x);
            end else if (cnt_ff == 5'd1) begin
               mul_a = abs32(cmd_ff.mom_y);
            end else begin
               mul_a = {1'b0, cmd_ff.mass};
            end
            mul_b = mul_a;
         end
         S_LOG: begin
            mul_a = {1'b0, mant_ff};
            mul_b = {1'b0, mant_ff};
         end
         S_LN: begin
            mul_a = (cnt_ff == 5'd0) ? {14'd0, d_ff[17:0]} : {15'd0, d_ff[34:18]};
            mul_b = {8'd0, LN2_Q24};
         end
         S_BIN: begin
            mul_a = diff_ff;
            mul_b = cfg.bin_scale;
         end
         default: begin
         end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      clr_in     = clr_ff;
      cmd_in     = cmd_ff;
      pass_in    = pass_ff;
      events_in  = events_ff;
      sqp_in     = sqp_ff;
      s1_in      = s1_ff;
      s2_in      = s2_ff;
      a_in       = a_ff;
      na_in      = na_ff;
      nb_in      = nb_ff;
      sa_in      = sa_ff;
      sb_in      = sb_ff;
      mant_in    = mant_ff;
      frac_in    = frac_ff;
      ph_in      = ph_ff;
      la_in      = la_ff;
      d_in       = d_ff;
      neg_in     = neg_ff;
      ln_in      = ln_ff;
      y_in       = y_ff;
      diff_in    = diff_ff;
      bin_in     = bin_ff;
      res_acc_in = res_acc_ff;
      res_bin_in = res_bin_ff;
      res_cnt_in = res_cnt_ff;
      rv_in      = rv_ff;
      pop        = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = bin_ff;
      ram_wdata  = '0;
      ram_raddr  = bin_ff;
      out_free   = !rv_ff || rsp_ready;
      sbit       = 64'd1 << (6'd62 - {cnt_ff, 1'b0});
      sqv        = prod[61:30];
      shk        = 5'd16 >> cnt_ff[2:0];
      lbv        = '0;
      lnsum      = ln_ff + {1'b0, prod[40:0], 18'd0} + 60'(64'd1 << 37);
      mag        = lnsum[59:38];
      y33        = {y_ff[31], y_ff};
      vmin       = {cfg.value_window[31], cfg.value_window[31:0]};
      vmax       = {cfg.value_window[63], cfg.value_window[63:32]};
      rmin       = {cfg.rapidity_window[31], cfg.rapidity_window[31:0]};
      rmax       = {cfg.rapidity_window[63], cfg.rapidity_window[63:32]};
      val        = (cfg.control[1:0] == OBS_PT) ? {1'b0, s1_ff.r[31:0]} : y33;
      dv         = val - vmin;
      idx        = prod[63:32];
      oldc       = ram_rdata;
      addv       = cfg.control[2] ? 32'd1 : 32'd2;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(NUM_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               pop        = 1'b1;
               cmd_in     = q_cmd;
               cnt_in     = '0;
               res_acc_in = 1'b0;
               res_bin_in = '0;
               res_cnt_in = '0;
               state_in   = S_OUT;
               case (q_cmd.func)
                  FUNC_EVENT: begin
                     pass_in    = q_cmd.ev_pass;
                     res_acc_in = q_cmd.ev_pass;
                     if (q_cmd.ev_pass && events_ff != '1) begin
                        events_in = events_ff + 1'b1;
                     end
                  end
                  FUNC_PARTICLE: begin
                     if (pass_ff && q_cmd.part_ok) begin
                        state_in = S_SQ;
                        a_in     = {1'b0, q_cmd.energy} + abs32(q_cmd.mom_z);
                     end
                  end
                  FUNC_READ: begin
                     ram_raddr  = AW'(q_cmd.read_index);
                     res_bin_in = q_cmd.read_index;
                     state_in   = S_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SQ: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd0) begin
               sqp_in = prod;
            end else if (cnt_ff == 5'd1) begin
               sqp_in = sqp_ff + prod;
            end else begin
               s1_in.v  = sqp_ff;
               s1_in.r  = '0;
               s2_in.v  = sqp_ff + prod;
               s2_in.r  = '0;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            s1_in  = sqrt_step(s1_ff, sbit);
            s2_in  = sqrt_step(s2_ff, sbit);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               cnt_in = '0;
               na_in  = a_ff;
               nb_in  = s2_in.r[31:0];
               sa_in  = '0;
               sb_in  = '0;
               // undefined rapidity: reject
               state_in = (a_ff == '0 || s2_in.r[31:0] == '0) ? S_OUT : S_NORM;
            end
         end
         S_NORM: begin
            if ((na_ff >> (6'd32 - {1'b0, shk})) == '0) begin
               na_in = na_ff << shk;
               sa_in = sa_ff + shk;
            end
            if ((nb_ff >> (6'd32 - {1'b0, shk})) == '0) begin
               nb_in = nb_ff << shk;
               sb_in = sb_ff + shk;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd4) begin
               cnt_in   = '0;
               mant_in  = na_in[31:1];
               frac_in  = '0;
               ph_in    = 1'b0;
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            if (sqv[31]) begin
               mant_in = sqv[31:1];
               frac_in = frac_ff | (30'd1 << (5'd29 - cnt_ff));
            end else begin
               mant_in = sqv[30:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd29) begin
               cnt_in = '0;
               if (!ph_ff) begin
                  la_in   = {5'd31 - sa_ff, frac_in};
                  mant_in = nb_ff[31:1];
                  frac_in = '0;
                  ph_in   = 1'b1;
               end else begin
                  lbv      = {5'd31 - sb_ff, frac_in};
                  neg_in   = la_ff < lbv;
                  d_in     = (la_ff < lbv) ? lbv - la_ff : la_ff - lbv;
                  state_in = S_LN;
               end
            end
         end
         S_LN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd0) begin
               ln_in = {18'd0, prod[41:0]};
            end else begin
               y_in     = (neg_ff ^ cmd_ff.mom_z[31]) ? -$signed({10'd0, mag})
                                                      : $signed({10'd0, mag});
               cnt_in   = '0;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            diff_in  = dv[31:0];
            state_in = S_BIN;
            if (cfg.control[1] || val < vmin || val > vmax || y33 < rmin || y33 > rmax) begin
               state_in = S_OUT;
            end
         end
         S_BIN: begin
            bin_in    = (idx >= 32'(NUM_BINS)) ? AW'(NUM_BINS - 1) : AW'(idx);
            ram_raddr = bin_in;
            state_in  = S_UPD;
         end
         S_UPD: begin
            ram_we     = 1'b1;
            ram_waddr  = bin_ff;
            ram_wdata  = (oldc > ~addv) ? '1 : oldc + addv;
            res_acc_in = 1'b1;
            res_bin_in = 6'(bin_ff);
            res_cnt_in = ram_wdata;
            state_in   = S_OUT;
         end
         S_RD: begin
            res_cnt_in = ({26'd0, cmd_ff.read_index} < 32'(NUM_BINS)) ? ram_rdata : '0;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         cnt_ff    <= '0;
         pass_ff   <= 1'b0;
         events_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         cnt_ff    <= cnt_in;
         pass_ff   <= pass_in;
         events_ff <= events_in;
         rv_ff     <= rv_in;
      end
      cmd_ff     <= cmd_in;
      sqp_ff     <= sqp_in;
      s1_ff      <= s1_in;
      s2_ff      <= s2_in;
      a_ff       <= a_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      mant_ff    <= mant_in;
      frac_ff    <= frac_in;
      ph_ff      <= ph_in;
      la_ff      <= la_in;
      d_ff       <= d_in;
      neg_ff     <= neg_in;
      ln_ff      <= ln_in;
      y_ff       <= y_in;
      diff_ff    <= diff_in;
      bin_ff     <= bin_in;
      res_acc_ff <= res_acc_in;
      res_bin_ff <= res_bin_in;
      res_cnt_ff <= res_cnt_in;
      if (state_ff == S_OUT && out_free) begin
         racc_ff <= res_acc_ff;
         rbin_ff <= res_bin_ff;
         rcnt_ff <= res_cnt_ff;
         revt_ff <= events_ff;
      end
   end

   assign clearing        = state_ff == S_CLEAR;
   assign rsp_valid       = rv_ff;
   assign rsp_accepted    = racc_ff;
   assign rsp_bin_index   = rbin_ff;
   assign rsp_bin_count   = rcnt_ff;
   assign rsp_event_count = revt_ff;

`ifndef ASSERT_OFF
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !pop) else $error("request taken during clear");
   a_events_mono: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_CLEAR |=> events_ff >= $past(events_ff))
      else $error("event count went down");
   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD |=> res_acc_ff && res_cnt_ff != '0)
      else $error("filled bin reads zero");
   a_load_only_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside output state");
`endif
endmodule

// ----- rtl/particle_spectrum_trigger_histogram.sv -----
`timescale 1ns / 1ps
// Transverse momentum / rapidity histogram with a centrality trigger.
// Request channel (req_valid/req_ready): event start, particle or bin read,
// selected by req_func. Every request gives exactly one response on the
// rsp_valid/rsp_ready channel, in request order.
// Registers are written through csr_valid/csr_ready/csr_index/csr_wdata,
// always ready; the user must write them only while no request is in
// flight, which the block does not enforce. From acceptance, an event
// start, unused codes and particles dropped by the event, status or id
// checks go straight to the output register, a bin read first reads the
// memory, and a particle that is worked out goes through 3 squarings, 32
// square-root digits (no further when they show an undefined rapidity), 5
// normalising steps, 60 log squarings, 2 scaling products, the window check
// and the bin update, all on one 32x32 multiplier, which sets the rate. One
// request is worked at a time; a two-entry queue in front keeps taking
// requests while the back end is busy or a response waits. After reset the
// histogram memory is cleared, one bin a cycle, through all NUM_BINS bins;
// req_ready stays low until that ends. Registers return to their defaults
// at reset. When the receiver stalls the response is held in the output
// register, the back end waits and the queue fills, then req_ready drops.
module particle_spectrum_trigger_histogram #(
   parameter int NUM_BINS = 64,
   parameter int MAX_IDS  = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_impact_param,
   input  logic [15:0]        req_particle_status,
   input  logic signed [15:0] req_particle_id,
   input  logic signed [31:0] req_mom_x,
   input  logic signed [31:0] req_mom_y,
   input  logic signed [31:0] req_mom_z,
   input  logic [30:0]        req_energy_in,
   input  logic [30:0]        req_mass_in,
   input  logic [5:0]         req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic [5:0]         rsp_bin_index,
   output logic [31:0]        rsp_bin_count,
   output logic [31:0]        rsp_event_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import pst_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, q_cmd;
   logic    push, q_full, q_valid, pop, clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CONTROL:    cfg_in.control           = csr_wdata[5:0];
            REG_VALUE_WIN:  cfg_in.value_window      = csr_wdata;
            REG_RAP_WIN:    cfg_in.rapidity_window   = csr_wdata;
            REG_CENT_WIN:   cfg_in.centrality_window = csr_wdata[31:0];
            REG_STATUS_WIN: cfg_in.status_window     = csr_wdata[31:0];
            REG_ID_LIST:    cfg_in.id_list           = csr_wdata;
            REG_BIN_SCALE:  cfg_in.bin_scale         = csr_wdata[31:0];
            REG_CENT_EN:    cfg_in.centrality_enable = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control           <= 6'd17;
         cfg_ff.value_window      <= '0;
         cfg_ff.rapidity_window   <= '0;
         cfg_ff.centrality_window <= '0;
         cfg_ff.status_window     <= 32'h0001_0000;
         cfg_ff.id_list           <= '0;
         cfg_ff.bin_scale         <= 32'h0001_0000;
         cfg_ff.centrality_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   pst_front #(.MAX_IDS(MAX_IDS)) u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_impact_param    (req_impact_param),
      .req_particle_status (req_particle_status),
      .req_particle_id     (req_particle_id),
      .req_mom_x           (req_mom_x),
      .req_mom_y           (req_mom_y),
      .req_mom_z           (req_mom_z),
      .req_energy_in       (req_energy_in),
      .req_mass_in         (req_mass_in),
      .req_read_index      (req_read_index),
      .cfg                 (cfg_ff),
      .clearing            (clearing),
      .q_full              (q_full),
      .push                (push),
      .push_cmd            (push_cmd)
   );

   pst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .q_valid  (q_valid),
      .pop      (pop),
      .q_cmd    (q_cmd)
   );

   pst_back #(.NUM_BINS(NUM_BINS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accepted    (rsp_accepted),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_event_count (rsp_event_count)
   );
endmodule
